>>> hdl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by the channel interfaces and every module of the block.
package lkvc_pkg;

  localparam int DEFAULT_ENTRIES = 16;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [KEY_W-1:0] NO_KEY = 32'sd0;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

endpackage

>>> hdl/lkvc_ifs.sv
// Valid/ready channel interfaces: request, response and capacity write.
// Depends on lkvc_pkg for field widths.
interface lkvc_req_if;
  import lkvc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, op, key, value, input ready);
  modport sink (input valid, op, key, value, output ready);
endinterface

interface lkvc_rsp_if;
  import lkvc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lkvc_cfg_if;
  import lkvc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hdl/lkvc_in_stage.sv
// Input register of the cache: holds one request beat for the lookup stage.
// Depends on lkvc_pkg and lkvc_req_if.
module lkvc_in_stage (
  input  logic           clk,
  input  logic           rst,
  lkvc_req_if.sink       req,
  input  logic           advance,
  output logic           busy,
  output lkvc_pkg::req_t item
);
  import lkvc_pkg::*;

  logic full;
  logic full_next;
  logic take;

  // Take a new beat when empty or when the held one moves on
  assign req.ready = !full || advance;
  assign take      = req.valid && req.ready;
  assign busy      = full;

  always_comb begin
    full_next = full;
    if (take) begin
      full_next = 1'b1;
    end else if (advance) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // Load the payload; no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      item.op    <= op_t'(req.op);
      item.key   <= req.key;
      item.value <= req.value;
    end
  end

endmodule

>>> hdl/lkvc_store.sv
// Entry store of the cache: keys, values, valid bits, ages, count and capacity.
// Computes one response per request in a single pass. Depends on lkvc_pkg.
module lkvc_store #(
  parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  lkvc_pkg::req_t item,
  lkvc_cfg_if.sink       cfg,
  output lkvc_pkg::rsp_t result
);
  import lkvc_pkg::*;

  localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  logic signed [KEY_W-1:0] entry_key   [ENTRIES];
  logic signed [VAL_W-1:0] entry_value [ENTRIES];
  logic [ENTRIES-1:0]      entry_valid;
  logic [AGE_W-1:0]        entry_age   [ENTRIES];
  logic [CNT_W-1:0]        entry_count;
  logic [CAP_W-1:0]        capacity;

  logic [CMP_W-1:0]        eff_cap;
  logic [AGE_W-1:0]        oldest_age;
  logic [ENTRIES-1:0]      hit_vec;
  logic [ENTRIES-1:0]      old_vec;
  logic [ENTRIES-1:0]      free_vec;
  logic [ENTRIES-1:0]      dst_vec;
  logic signed [VAL_W-1:0] hit_value;
  logic [AGE_W-1:0]        hit_age;
  logic signed [KEY_W-1:0] old_key;
  logic                    hit;
  logic                    evict;
  logic                    do_set;

  assign cfg.ready = 1'b1;

  // Clamp capacity to 1 .. ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  // Valid ages are distinct 0 .. count-1, so the oldest has age count-1
  assign oldest_age = AGE_W'(entry_count - CNT_W'(1));

  // Compare all entries in parallel and fold the matches
  always_comb begin
    hit_value = '0;
    hit_age   = '0;
    old_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_key[i] == item.key);
      old_vec[i] = entry_valid[i] && (entry_age[i] == oldest_age);
      hit_value  = hit_value | (hit_vec[i] ? entry_value[i] : '0);
      hit_age    = hit_age | (hit_vec[i] ? entry_age[i] : '0);
      old_key    = old_key | (old_vec[i] ? entry_key[i] : '0);
    end
  end

  // Lowest free slot, one-hot
  assign free_vec = ~entry_valid & (entry_valid + ENTRIES'(1));

  assign hit     = |hit_vec;
  assign do_set  = advance && (item.op == OP_SET);
  assign evict   = (item.op == OP_SET) && !hit && (CMP_W'(entry_count) >= eff_cap);
  assign dst_vec = evict ? old_vec : free_vec;

  // Build the response beat
  always_comb begin
    result.hit         = hit;
    result.read_value  = (item.op == OP_GET && hit) ? hit_value : MISS_VALUE;
    result.evicted     = evict;
    result.evicted_key = evict ? old_key : NO_KEY;
  end

  // Update control state: valid bits, ages, count, capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
      capacity    <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.data;
      end
      if (do_set) begin
        if (hit) begin
          // Refresh the hit entry, age the younger ones
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit_vec[i]) begin
              entry_age[i] <= '0;
            end else if (entry_valid[i] && entry_age[i] < hit_age) begin
              entry_age[i] <= entry_age[i] + AGE_W'(1);
            end
          end
        end else begin
          // Insert into the free or evicted slot, age all others
          for (int i = 0; i < ENTRIES; i++) begin
            if (dst_vec[i]) begin
              entry_valid[i] <= 1'b1;
              entry_age[i]   <= '0;
            end else if (entry_valid[i]) begin
              entry_age[i] <= entry_age[i] + AGE_W'(1);
            end
          end
          if (!evict) begin
            entry_count <= entry_count + CNT_W'(1);
          end
        end
      end
    end
  end

  // Write key and value payload
  always_ff @(posedge clk) begin
    if (do_set) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit ? hit_vec[i] : dst_vec[i]) begin
          entry_value[i] <= item.value;
        end
        if (!hit && dst_vec[i]) begin
          entry_key[i] <= item.key;
        end
      end
    end
  end

endmodule

>>> hdl/lkvc_out_stage.sv
// Result register of the cache: holds one response beat until taken.
// Depends on lkvc_pkg and lkvc_rsp_if.
module lkvc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  lkvc_pkg::rsp_t result,
  output logic           room,
  lkvc_rsp_if.source     rsp
);
  import lkvc_pkg::*;

  logic full;
  logic full_next;
  rsp_t held;

  assign room = !full || rsp.ready;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (rsp.ready) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // Capture the response; no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign rsp.valid       = full;
  assign rsp.hit         = held.hit;
  assign rsp.read_value  = held.read_value;
  assign rsp.evicted     = held.evicted;
  assign rsp.evicted_key = held.evicted_key;

endmodule

>>> hdl/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: input register, entry store, result register.
// Depends on lkvc_pkg, the channel interfaces and the three stage modules.
//
//   channel  dir  fields
//   req      in   op, key, value
//   rsp      out  hit, read_value, evicted, evicted_key
//   cfg      in   data (capacity)
//
// One request per cycle while responses are taken. A request goes through the input
// register, then the result register; the lookup, age update and insert or overwrite
// are done combinationally between them, with all entries compared in parallel.
// Reset clears valid bits, ages and count at once; capacity resets to 16.
// A stalled response holds the result register, and the input register then holds its request.
module lru_key_value_cache_core #(
  parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  lkvc_req_if.sink   req,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink   cfg
);
  import lkvc_pkg::*;

  logic busy;
  logic room;
  logic advance;
  req_t item;
  rsp_t result;

  // Move a request through when the result register has room
  assign advance = busy && room;

  lkvc_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (advance),
    .busy    (busy),
    .item    (item)
  );

  lkvc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  lkvc_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .result (result),
    .room   (room),
    .rsp    (rsp)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for lru_key_value_cache_core: get/set traffic against an LRU tracker.
// Depends on lkvc_pkg and the channel interfaces (lkvc_req_if, lkvc_rsp_if, lkvc_cfg_if).
module tb;
  import lkvc_pkg::*;

  localparam int N_ENTRIES = DEFAULT_ENTRIES;
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int HOLD_CYCLES = 250;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Tracks the cache contents and the results they imply
  class cache_tracker;
    logic signed [KEY_W-1:0] keys [N_ENTRIES];
    logic signed [VAL_W-1:0] vals [N_ENTRIES];
    bit                      used [N_ENTRIES];
    logic [3:0]              age [N_ENTRIES];
    logic [CAP_W-1:0]        count;
    logic [CAP_W-1:0]        capacity;
    rsp_t                    pending_results[$];
    int                      errors;

    function new();
      for (int i = 0; i < N_ENTRIES; i++) begin
        used[i] = 1'b0;
        age[i] = '0;
      end
      count = '0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    // Zero behaves as one, anything past the store size saturates
    function int capacity_limit();
      if (capacity < 1) return 1;
      if (capacity > N_ENTRIES) return N_ENTRIES;
      return int'(capacity);
    endfunction

    function void note_request(req_t r);
      int   slot;
      int   dst;
      int   oldest;
      logic [3:0] old_age;
      rsp_t e;
      slot = -1;
      for (int i = 0; i < N_ENTRIES; i++)
        if (slot < 0 && used[i] && keys[i] == r.key) slot = i;
      e.hit = (slot >= 0);
      e.read_value = MISS_VALUE;
      e.evicted = 1'b0;
      e.evicted_key = NO_KEY;
      if (r.op == OP_GET) begin
        if (slot >= 0) e.read_value = vals[slot];
      end else if (slot >= 0) begin
        // Overwrite and promote: only younger entries age
        old_age = age[slot];
        for (int i = 0; i < N_ENTRIES; i++)
          if (used[i] && age[i] < old_age) age[i] = age[i] + 1'b1;
        age[slot] = '0;
        vals[slot] = r.value;
      end else begin
        dst = -1;
        // Evict the oldest entry when the insert would overflow
        if (int'(count) + 1 > capacity_limit()) begin
          oldest = -1;
          for (int i = 0; i < N_ENTRIES; i++)
            if (used[i] && (oldest < 0 || age[i] > age[oldest])) oldest = i;
          if (oldest >= 0) begin
            e.evicted = 1'b1;
            e.evicted_key = keys[oldest];
            used[oldest] = 1'b0;
            age[oldest] = '0;
            if (count > 0) count = count - 1'b1;
            dst = oldest;
          end
        end
        if (dst < 0) begin
          for (int i = 0; i < N_ENTRIES; i++)
            if (dst < 0 && !used[i]) dst = i;
        end
        if (dst >= 0) begin
          for (int i = 0; i < N_ENTRIES; i++)
            if (used[i]) age[i] = age[i] + 1'b1;
          used[dst] = 1'b1;
          keys[dst] = r.key;
          vals[dst] = r.value;
          age[dst] = '0;
          count = count + 1'b1;
        end
      end
      pending_results.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0b read_value=%h evicted=%0b evicted_key=%h",
                 $time, got.hit, got.read_value, got.evicted, got.evicted_key);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.hit !== e.hit) begin
        $display("%0t: hit mismatch expected %0b actual %0b", $time, e.hit, got.hit);
        errors++;
      end
      if (got.read_value !== e.read_value) begin
        $display("%0t: read_value mismatch expected %h actual %h",
                 $time, e.read_value, got.read_value);
        errors++;
      end
      if (got.evicted !== e.evicted) begin
        $display("%0t: evicted mismatch expected %0b actual %0b", $time, e.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== e.evicted_key) begin
        $display("%0t: evicted_key mismatch expected %h actual %h",
                 $time, e.evicted_key, got.evicted_key);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();
  lkvc_cfg_if cfg_ch ();

  lru_key_value_cache_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  cache_tracker tracker = new();
  bit req_eager;
  bit rsp_eager;
  bit hold_armed;
  logic signed [KEY_W-1:0] key_pool[$];

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("[lru_key_value_cache_core] ERROR");
    $finish;
  end

  // Response side: check each beat, then pick ready for the next cycle
  initial begin
    int   stall_left;
    int   roll;
    rsp_t got;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.hit = rsp_ch.hit;
        got.read_value = rsp_ch.read_value;
        got.evicted = rsp_ch.evicted;
        got.evicted_key = rsp_ch.evicted_key;
        tracker.check_result(got);
      end
      if (hold_armed) begin
        stall_left = HOLD_CYCLES;
        hold_armed = 1'b0;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_eager) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          stall_left = $urandom_range(0, 2);
          rsp_ch.ready <= 1'b0;
        end else if (roll < 14) begin
          stall_left = $urandom_range(15, 40);
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Offer one request and hold it until the block takes it
  task automatic send_req(op_t op, logic signed [KEY_W-1:0] key, logic signed [VAL_W-1:0] value);
    req_t r;
    r.op = op;
    r.key = key;
    r.value = value;
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.key <= key;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(r);
  endtask

  // Drop valid for a random gap: mostly none, some short, a few long
  task automatic req_gap();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    n = 0;
    if (req_eager || roll < 70) n = 0;
    else if (roll < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Pause requests until every outstanding result is back, then let the pipe settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tracker.set_capacity(cap);
  endtask

  // Extremes, hit and miss, overwrite paths, eviction under small and odd capacities
  task automatic run_directed();
    send_req(OP_GET, 32'sd0, VAL_MAX);
    send_req(OP_SET, KEY_MIN, VAL_MAX);
    send_req(OP_SET, KEY_MAX, VAL_MIN);
    send_req(OP_SET, 32'sd0, 32'sd0);
    send_req(OP_SET, -32'sd1, -32'sd1);
    send_req(OP_GET, KEY_MIN, 32'sd0);
    send_req(OP_GET, KEY_MAX, -32'sd1);
    send_req(OP_GET, -32'sd1, 32'sd0);
    send_req(OP_SET, -32'sd1, 32'sd5);
    send_req(OP_SET, KEY_MIN, 32'sh5A5A_5A5A);
    send_req(OP_GET, 32'sd0, VAL_MIN);
    send_req(OP_GET, 32'sd77, 32'sd0);
    // Shrink below the current count: each insert now evicts one
    drain();
    write_capacity(5'd2);
    send_req(OP_SET, 32'sd101, 32'sd1);
    send_req(OP_SET, 32'sd102, 32'sd2);
    send_req(OP_GET, 32'sd101, 32'sd0);
    send_req(OP_SET, 32'sd103, 32'sd3);
    // Zero acts as a single entry
    drain();
    write_capacity(5'd0);
    send_req(OP_SET, 32'sd104, 32'sd4);
    send_req(OP_SET, 32'sd104, 32'sd6);
    send_req(OP_GET, 32'sd104, 32'sd0);
    send_req(OP_GET, 32'sd103, 32'sd0);
    // Over-range capacity saturates at the store size
    drain();
    write_capacity(5'd31);
    send_req(OP_SET, 32'sd105, VAL_MAX);
    send_req(OP_GET, 32'sd105, 32'sd0);
  endtask

  // Build a key pool a little larger than the capacity so hits and evictions both occur
  task automatic refill_pool(logic [CAP_W-1:0] cap);
    int lim;
    int n;
    lim = (cap < 1) ? 1 : ((cap > N_ENTRIES) ? N_ENTRIES : int'(cap));
    n = lim + $urandom_range(1, 6);
    key_pool.delete();
    key_pool.push_back(KEY_MIN);
    key_pool.push_back(KEY_MAX);
    key_pool.push_back(32'sd0);
    key_pool.push_back(-32'sd1);
    while (key_pool.size() < n) key_pool.push_back($urandom);
  endtask

  task automatic run_random(int n_items);
    op_t op;
    logic signed [KEY_W-1:0] key;
    for (int i = 0; i < n_items; i++) begin
      op = op_t'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else key = $urandom;
      send_req(op, key, $urandom);
      req_gap();
    end
  endtask

  // Main sequence
  initial begin
    logic [CAP_W-1:0] caps [10];
    caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd5, 5'd17, 5'd2, 5'd12, 5'd16, 5'd8};
    caps[8] = CAP_W'($urandom_range(0, 31));
    req_eager = 1'b0;
    rsp_eager = 1'b0;
    hold_armed = 1'b0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_GET;
    req_ch.key <= '0;
    req_ch.value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_capacity(5'd16);
    run_directed();

    for (int p = 0; p < 10; p++) begin
      drain();
      write_capacity(caps[p]);
      refill_pool(caps[p]);
      // Some phases run back to back on the request side, the response side or both
      req_eager = (p == 2 || p == 5);
      rsp_eager = (p == 5 || p == 7);
      // Long response stall while requests keep coming, to back up the pipe
      if (p == 2) hold_armed = 1'b1;
      run_random(ITEMS_PER_PHASE);
    end

    drain();
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("[lru_key_value_cache_core] OK");
    end else begin
      $display("[lru_key_value_cache_core] ERROR");
    end
    $finish;
  end

endmodule
